@@ hw/rtl/pbrc_pkg.sv @@
// Shared widths, codes and sizes for the pinned block region cache.
`default_nettype none
package pbrc_pkg;

    localparam int SLOTS   = 2;
    localparam int STREAMS = 2;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PIN_W    = $clog2(STREAMS + 1);
    localparam int STREAM_W = 1;
    localparam int OFF_W    = 48;
    localparam int LEN_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SRC_W    = 2;
    localparam int STEP_W   = $clog2(OFF_W);

    localparam int S_DATA_BITS = STREAM_W + OFF_W + LEN_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 1 + LEN_W + LEN_W + 1 + OFF_W + LEN_W + CNT_W + CNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_USER_W    = 1 + SRC_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK  = 2'd2;

    localparam logic [LEN_W-1:0] BLOCK_SIZE_RESET = 32'd65536;

    localparam logic CMD_RESOLVE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [SRC_W-1:0] SRC_EMPTY   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_SLOT    = 2'd1;
    localparam logic [SRC_W-1:0] SRC_SCRATCH = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/pinned_block_region_cache_top.sv @@
// Pinned block region cache: window check, serial block divide, slot lookup and pinning.
//
//  channel | direction | beat contents
//  s_      | in        | tuser: cmd; tdata: stream, abs_off, win_len
//  m_      | out       | tuser: status, source; tdata: slot_id .. stream_hits
//  cfg_    | in        | cfg_index, cfg_data (region base, region size, block_size)
//
// A resolve beat that passes the range checks goes from acceptance through the base, end
// and length checks, the bit-serial remainder by block_size, alignment, block offset,
// block length, fit, slot lookup and result. Errors and zero lengths go to the result from
// their check, a release directly. One beat is in work at a time; s_tready is high only when idle.
// A held result in the output register does not stop acceptance; a new result waits
// for it to drain. Reset is synchronous and leaves all slots empty and unpinned.
`default_nettype none
module pinned_block_region_cache_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [0] stream, [48:1] abs_off, [80:49] win_len, rest zero
    input  wire logic [pbrc_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] cmd
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] slot_id, [32:1] slice_off, [64:33] slice_len, [65] read_issue,
    // [113:66] read_off, [145:114] read_len, [177:146] stream_reads,
    // [209:178] stream_hits, rest zero
    output logic [pbrc_pkg::M_DATA_W-1:0]        m_tdata,
    // [0] status, [2:1] source
    output logic [pbrc_pkg::M_USER_W-1:0]        m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pbrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK_BASE, ST_CHK_END, ST_CHK_LEN, ST_DIV, ST_ALIGN,
        ST_BLK_OFF, ST_BLK_LEN, ST_FIT, ST_LOOK, ST_RELEASE, ST_DONE
    } state_t;

    state_t state_reg;

    logic [OFF_W-1:0] region_base_reg;
    logic [OFF_W-1:0] region_size_reg;
    logic [LEN_W-1:0] block_size_reg;

    logic [OFF_W-1:0] slot_block_off_reg [SLOTS];
    logic [LEN_W-1:0] slot_len_reg       [SLOTS];
    logic             slot_valid_reg     [SLOTS];
    logic [PIN_W-1:0] slot_pin_reg       [SLOTS];
    logic             has_pin_reg        [STREAMS];
    logic [SLOT_W-1:0] pinned_slot_reg   [STREAMS];
    logic [CNT_W-1:0] read_cnt_reg       [STREAMS];
    logic [CNT_W-1:0] hit_cnt_reg        [STREAMS];

    logic [STREAM_W-1:0] stream_reg;
    logic [OFF_W-1:0]    abs_off_reg;
    logic [LEN_W-1:0]    win_len_reg;
    logic [OFF_W-1:0]    rel_reg;
    logic [OFF_W-1:0]    lrem_reg;
    logic [OFF_W-1:0]    dvd_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [OFF_W-1:0]    aligned_reg;
    logic [OFF_W-1:0]    blk_off_reg;
    logic [LEN_W-1:0]    blk_len_reg;
    logic [LEN_W:0]      end_reg;
    logic                fits_reg;

    logic                status_reg;
    logic [SRC_W-1:0]    source_reg;
    logic [SLOT_W-1:0]   slot_id_reg;
    logic [LEN_W-1:0]    slice_off_reg;
    logic [LEN_W-1:0]    slice_len_reg;
    logic                rd_issue_reg;
    logic [OFF_W-1:0]    rd_off_reg;
    logic [LEN_W-1:0]    rd_len_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic [LEN_W-1:0]  bs_eff;
    logic [LEN_W:0]    div_trial;
    logic [LEN_W+1:0]  div_diff;
    logic [LEN_W-1:0]  rem_next;
    logic [OFF_W:0]    rel_next;
    logic [OFF_W-1:0]  rest_next;
    logic              len_err;
    logic              do_drop;
    logic [SLOT_W-1:0] drop_slot;
    logic              hit_any;
    logic              free_any;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign bs_eff    = (block_size_reg == '0) ? LEN_W'(1) : block_size_reg;
    assign div_trial = {rem_reg, dvd_reg[OFF_W-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, bs_eff};
    assign rem_next  = div_diff[LEN_W+1] ? div_trial[LEN_W-1:0] : div_diff[LEN_W-1:0];
    assign rel_next  = {1'b0, abs_off_reg} - {1'b0, region_base_reg};
    assign rest_next = region_size_reg - aligned_reg;
    assign len_err   = {{(OFF_W-LEN_W){1'b0}}, win_len_reg} > lrem_reg;
    assign do_drop   = (state_reg == ST_RELEASE) || ((state_reg == ST_CHK_LEN) && !len_err);
    assign drop_slot = pinned_slot_reg[stream_reg];

    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (slot_valid_reg[k] && (slot_block_off_reg[k] == blk_off_reg) &&
                (end_reg <= {1'b0, slot_len_reg[k]})) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(k);
            end
            if (slot_pin_reg[k] == '0) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            region_base_reg   <= '0;
            region_size_reg   <= '0;
            block_size_reg    <= BLOCK_SIZE_RESET;
            for (int k = 0; k < SLOTS; k++) begin
                slot_block_off_reg[k] <= '0;
                slot_len_reg[k]       <= '0;
                slot_valid_reg[k]     <= 1'b0;
                slot_pin_reg[k]       <= '0;
            end
            for (int s = 0; s < STREAMS; s++) begin
                has_pin_reg[s]     <= 1'b0;
                pinned_slot_reg[s] <= '0;
                read_cnt_reg[s]    <= '0;
                hit_cnt_reg[s]     <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_BASE:   region_base_reg   <= cfg_data;
                    REG_LENGTH: region_size_reg   <= cfg_data;
                    REG_BLOCK:  block_size_reg    <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            if (do_drop && has_pin_reg[stream_reg]) begin
                if (slot_pin_reg[drop_slot] != '0) begin
                    slot_pin_reg[drop_slot] <= slot_pin_reg[drop_slot] - PIN_W'(1);
                end
                has_pin_reg[stream_reg]     <= 1'b0;
                pinned_slot_reg[stream_reg] <= '0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        stream_reg    <= s_tdata[0];
                        abs_off_reg   <= s_tdata[OFF_W:1];
                        win_len_reg   <= s_tdata[OFF_W+LEN_W:OFF_W+1];
                        status_reg    <= STATUS_OK;
                        source_reg    <= SRC_EMPTY;
                        slot_id_reg   <= '0;
                        slice_off_reg <= '0;
                        slice_len_reg <= '0;
                        rd_issue_reg  <= 1'b0;
                        rd_off_reg    <= '0;
                        rd_len_reg    <= '0;
                        state_reg     <= (s_tuser == CMD_RELEASE) ? ST_RELEASE : ST_CHK_BASE;
                    end
                end
                ST_RELEASE: begin
                    state_reg <= ST_DONE;
                end
                ST_CHK_BASE: begin
                    rel_reg <= rel_next[OFF_W-1:0];
                    if (rel_next[OFF_W]) begin
                        status_reg <= STATUS_RANGE;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_CHK_END;
                    end
                end
                ST_CHK_END: begin
                    lrem_reg <= region_size_reg - rel_reg;
                    if (rel_reg > region_size_reg) begin
                        status_reg <= STATUS_RANGE;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_CHK_LEN;
                    end
                end
                ST_CHK_LEN: begin
                    dvd_reg  <= rel_reg;
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (len_err) begin
                        status_reg <= STATUS_RANGE;
                        state_reg  <= ST_DONE;
                    end else if (win_len_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[OFF_W-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(OFF_W - 1)) begin
                        state_reg <= ST_ALIGN;
                    end
                end
                ST_ALIGN: begin
                    aligned_reg <= rel_reg - {{(OFF_W-LEN_W){1'b0}}, rem_reg};
                    state_reg   <= ST_BLK_OFF;
                end
                ST_BLK_OFF: begin
                    blk_off_reg <= region_base_reg + aligned_reg;
                    state_reg   <= ST_BLK_LEN;
                end
                ST_BLK_LEN: begin
                    if (rest_next < {{(OFF_W-LEN_W){1'b0}}, bs_eff}) begin
                        blk_len_reg <= rest_next[LEN_W-1:0];
                    end else begin
                        blk_len_reg <= bs_eff;
                    end
                    state_reg <= ST_FIT;
                end
                ST_FIT: begin
                    fits_reg  <= win_len_reg <= (blk_len_reg - rem_reg);
                    end_reg   <= {1'b0, rem_reg} + {1'b0, win_len_reg};
                    state_reg <= ST_LOOK;
                end
                ST_LOOK: begin
                    slice_len_reg <= win_len_reg;
                    if (fits_reg && hit_any) begin
                        slot_pin_reg[hit_idx]       <= slot_pin_reg[hit_idx] + PIN_W'(1);
                        has_pin_reg[stream_reg]     <= 1'b1;
                        pinned_slot_reg[stream_reg] <= hit_idx;
                        if (hit_cnt_reg[stream_reg] != '1) begin
                            hit_cnt_reg[stream_reg] <= hit_cnt_reg[stream_reg] + CNT_W'(1);
                        end
                        source_reg    <= SRC_SLOT;
                        slot_id_reg   <= hit_idx;
                        slice_off_reg <= rem_reg;
                    end else begin
                        if (read_cnt_reg[stream_reg] != '1) begin
                            read_cnt_reg[stream_reg] <= read_cnt_reg[stream_reg] + CNT_W'(1);
                        end
                        rd_issue_reg <= 1'b1;
                        if (fits_reg && free_any) begin
                            slot_block_off_reg[free_idx] <= blk_off_reg;
                            slot_len_reg[free_idx]       <= blk_len_reg;
                            slot_valid_reg[free_idx]     <= 1'b1;
                            slot_pin_reg[free_idx]       <= PIN_W'(1);
                            has_pin_reg[stream_reg]      <= 1'b1;
                            pinned_slot_reg[stream_reg]  <= free_idx;
                            source_reg    <= SRC_SLOT;
                            slot_id_reg   <= free_idx;
                            slice_off_reg <= rem_reg;
                            rd_off_reg    <= blk_off_reg;
                            rd_len_reg    <= blk_len_reg;
                        end else begin
                            source_reg <= SRC_SCRATCH;
                            rd_off_reg <= abs_off_reg;
                            rd_len_reg <= win_len_reg;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {source_reg, status_reg};
                        m_tdata_reg  <= {{(M_DATA_W-M_DATA_BITS){1'b0}},
                                         hit_cnt_reg[stream_reg], read_cnt_reg[stream_reg],
                                         rd_len_reg, rd_off_reg, rd_issue_reg,
                                         slice_len_reg, slice_off_reg, slot_id_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ dv/tb_pinned_block_region_cache_top.sv @@
// Self-checking testbench for the pinned block region cache: directed cases, then random windows.
module tb_pinned_block_region_cache_top;
    import pbrc_pkg::*;

    localparam int TIMEOUT = 1_200_000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic             status;
        logic [SRC_W-1:0] source;
        logic [SLOT_W-1:0] slot_id;
        logic [LEN_W-1:0] slice_off;
        logic [LEN_W-1:0] slice_len;
        logic             read_issue;
        logic [OFF_W-1:0] read_off;
        logic [LEN_W-1:0] read_len;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] hits;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // [0] stream, [48:1] abs_off, [80:49] win_len, rest zero
    logic [S_DATA_W-1:0] s_tdata = '0;
    // [0] cmd
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [0] slot_id, [32:1] slice_off, [64:33] slice_len, [65] read_issue, [113:66] read_off,
    // [145:114] read_len, [177:146] stream_reads, [209:178] stream_hits, rest zero
    logic [M_DATA_W-1:0] m_tdata;
    // [0] status, [2:1] source
    logic [M_USER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pinned_block_region_cache_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // cache mirror
    logic [63:0] region_base_m;
    logic [63:0] region_len_m;
    logic [63:0] block_size_m;
    logic [63:0] slot_blk [SLOTS];
    logic [63:0] slot_fill [SLOTS];
    logic        slot_live [SLOTS];
    int unsigned slot_pins [SLOTS];
    logic        pin_held [STREAMS];
    int unsigned pin_slot [STREAMS];
    logic [CNT_W-1:0] rd_cnt [STREAMS];
    logic [CNT_W-1:0] hit_cnt [STREAMS];

    outcome_t pending_outcomes [$];
    outcome_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int n_beats = 0, n_release = 0, n_range = 0, n_empty = 0;
    int n_hit = 0, n_fill = 0, n_scratch = 0, n_settings = 0;

    function automatic void clear_mirror();
        region_base_m = '0;
        region_len_m = '0;
        block_size_m = 64'(BLOCK_SIZE_RESET);
        for (int k = 0; k < SLOTS; k++) begin
            slot_blk[k] = '0;
            slot_fill[k] = '0;
            slot_live[k] = 1'b0;
            slot_pins[k] = 0;
        end
        for (int k = 0; k < STREAMS; k++) begin
            pin_held[k] = 1'b0;
            pin_slot[k] = 0;
            rd_cnt[k] = '0;
            hit_cnt[k] = '0;
        end
    endfunction

    function automatic void drop_stream_pin(logic st);
        if (pin_held[st]) begin
            if (slot_pins[pin_slot[st] % SLOTS] > 0) slot_pins[pin_slot[st] % SLOTS]--;
            pin_held[st] = 1'b0;
            pin_slot[st] = 0;
        end
    endfunction

    function automatic outcome_t cache_outcome(logic cmd, logic st, logic [OFF_W-1:0] off,
                                               logic [LEN_W-1:0] len);
        outcome_t o;
        logic [63:0] a, ln, rel, bs, aligned, blk_off, rest, blk_len, in_blk;
        int hit, free_slot;
        o = '0;
        hit = -1;
        free_slot = -1;
        a = 64'(off);
        ln = 64'(len);
        if (int'(st) >= STREAMS) return o;
        if (cmd == CMD_RELEASE) begin
            drop_stream_pin(st);
        end else if (a < region_base_m || a - region_base_m > region_len_m ||
                     ln > region_len_m - (a - region_base_m)) begin
            o.status = STATUS_RANGE;
        end else begin
            rel = a - region_base_m;
            bs = (block_size_m == 0) ? 64'd1 : block_size_m;
            aligned = (rel / bs) * bs;
            blk_off = region_base_m + aligned;
            rest = region_len_m - aligned;
            blk_len = (bs < rest) ? bs : rest;
            in_blk = rel - aligned;
            drop_stream_pin(st);
            if (ln != 0) begin
                if (ln <= blk_len - in_blk) begin
                    for (int k = 0; k < SLOTS; k++)
                        if (hit < 0 && slot_live[k] && slot_blk[k] == blk_off &&
                            in_blk + ln <= slot_fill[k]) hit = k;
                    if (hit < 0)
                        for (int k = 0; k < SLOTS; k++)
                            if (free_slot < 0 && slot_pins[k] == 0) free_slot = k;
                end
                if (hit >= 0) begin
                    slot_pins[hit]++;
                    pin_held[st] = 1'b1;
                    pin_slot[st] = hit;
                    if (hit_cnt[st] != '1) hit_cnt[st]++;
                    o.source = SRC_SLOT;
                    o.slot_id = hit[SLOT_W-1:0];
                    o.slice_off = in_blk[LEN_W-1:0];
                    o.slice_len = len;
                end else if (free_slot >= 0) begin
                    slot_blk[free_slot] = blk_off;
                    slot_fill[free_slot] = blk_len;
                    slot_live[free_slot] = 1'b1;
                    slot_pins[free_slot] = 1;
                    pin_held[st] = 1'b1;
                    pin_slot[st] = free_slot;
                    if (rd_cnt[st] != '1) rd_cnt[st]++;
                    o.source = SRC_SLOT;
                    o.slot_id = free_slot[SLOT_W-1:0];
                    o.slice_off = in_blk[LEN_W-1:0];
                    o.slice_len = len;
                    o.read_issue = 1'b1;
                    o.read_off = blk_off[OFF_W-1:0];
                    o.read_len = blk_len[LEN_W-1:0];
                end else begin
                    if (rd_cnt[st] != '1) rd_cnt[st]++;
                    o.source = SRC_SCRATCH;
                    o.slice_len = len;
                    o.read_issue = 1'b1;
                    o.read_off = off;
                    o.read_len = len;
                end
            end
        end
        o.reads = rd_cnt[st];
        o.hits = hit_cnt[st];
        return o;
    endfunction

    function automatic logic [63:0] rand_below(logic [63:0] n);
        if (n == 0) return '0;
        return {$urandom, $urandom} % n;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no outstanding request");
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser[0]));
                check_field("source", 64'(want.source), 64'(m_tuser[2:1]));
                check_field("slot_id", 64'(want.slot_id), 64'(m_tdata[0]));
                check_field("slice_off", 64'(want.slice_off), 64'(m_tdata[32:1]));
                check_field("slice_len", 64'(want.slice_len), 64'(m_tdata[64:33]));
                check_field("read_issue", 64'(want.read_issue), 64'(m_tdata[65]));
                check_field("read_off", 64'(want.read_off), 64'(m_tdata[113:66]));
                check_field("read_len", 64'(want.read_len), 64'(m_tdata[145:114]));
                check_field("stream_reads", 64'(want.reads), 64'(m_tdata[177:146]));
                check_field("stream_hits", 64'(want.hits), 64'(m_tdata[209:178]));
                check_field("tdata_pad", '0, 64'(m_tdata[M_DATA_W-1:M_DATA_BITS]));
            end
        end
    end

    task automatic send_beat(logic cmd, logic st, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
        outcome_t o;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= S_DATA_W'({len, off, st});
        do @(posedge aclk); while (!s_tready);
        o = cache_outcome(cmd, st, off, len);
        pending_outcomes.push_back(o);
        n_beats++;
        if (cmd == CMD_RELEASE) n_release++;
        else if (o.status == STATUS_RANGE) n_range++;
        else if (o.source == SRC_EMPTY) n_empty++;
        else if (o.source == SRC_SCRATCH) n_scratch++;
        else if (o.read_issue) n_fill++;
        else n_hit++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BASE:   region_base_m = 64'(data);
            REG_LENGTH: region_len_m = 64'(data);
            REG_BLOCK:  block_size_m = 64'(data[LEN_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_region(logic [OFF_W-1:0] base, logic [OFF_W-1:0] len,
                              logic [LEN_W-1:0] bs);
        wait_drain();
        write_reg(REG_BASE, base);
        write_reg(REG_LENGTH, len);
        // upper bits of the block size beat are don't-care
        write_reg(REG_BLOCK, {16'($urandom), bs});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_defaults();
        send_beat(CMD_RESOLVE, 1'b0, '0, '0);
        send_beat(CMD_RESOLVE, 1'b1, '0, 32'd1);
        send_beat(CMD_RESOLVE, 1'b0, '1, '1);
        send_beat(CMD_RELEASE, 1'b1, '1, '1);
    endtask

    task automatic test_window_edges();
        set_region(48'h1000, 48'h2800, 32'h1000);
        send_beat(CMD_RESOLVE, 1'b0, 48'h0FFF, 32'd1);
        send_beat(CMD_RESOLVE, 1'b1, 48'h3800, 32'd0);
        send_beat(CMD_RESOLVE, 1'b1, 48'h3800, 32'd1);
        // clamped last block
        send_beat(CMD_RESOLVE, 1'b0, 48'h37F0, 32'h10);
        send_beat(CMD_RESOLVE, 1'b1, 48'h1FF0, 32'h20);
    endtask

    task automatic test_slot_pinning();
        send_beat(CMD_RESOLVE, 1'b1, 48'h1010, 32'h100);
        send_beat(CMD_RESOLVE, 1'b0, 48'h1200, 32'h10);
        send_beat(CMD_RESOLVE, 1'b1, 48'h2000, 32'h8);
        send_beat(CMD_RELEASE, 1'b0, '0, '0);
        send_beat(CMD_RELEASE, 1'b0, '0, '0);
        // out of range keeps the pin
        send_beat(CMD_RESOLVE, 1'b1, '1, 32'd4);
        send_beat(CMD_RESOLVE, 1'b0, 48'h2004, 32'h4);
        send_beat(CMD_RESOLVE, 1'b1, 48'h1000, 32'd0);
    endtask

    task automatic test_block_size_extremes();
        // zero block size behaves as one byte
        set_region(48'hFFFF_FFFF_F000, 48'h0FFF, 32'd0);
        send_beat(CMD_RESOLVE, 1'b0, 48'hFFFF_FFFF_F005, 32'd1);
        send_beat(CMD_RESOLVE, 1'b1, 48'hFFFF_FFFF_F005, 32'd2);
        set_region(48'd0, '1, '1);
        send_beat(CMD_RESOLVE, 1'b0, 48'hFFFF_FFFF_FFFE, 32'd1);
        send_beat(CMD_RESOLVE, 1'b1, 48'd0, '1);
        send_beat(CMD_RESOLVE, 1'b0, 48'd1, '1);
        set_region(48'd12345, 48'd100, 32'd1);
        send_beat(CMD_RESOLVE, 1'b1, 48'd12444, 32'd1);
    endtask

    task automatic random_region();
        logic [63:0] bs, eff, len, base;
        case ($urandom_range(0, 3))
            0: bs = 64'($urandom_range(1, 16));
            1: bs = 64'd1 << $urandom_range(4, 20);
            2: bs = 64'($urandom);
            default: bs = 64'($urandom_range(100, 5000));
        endcase
        eff = (bs == 0) ? 64'd1 : bs;
        if ($urandom_range(0, 7) == 0) len = rand_below(eff);
        else len = eff * 64'($urandom_range(1, 5)) + rand_below(eff);
        base = ($urandom_range(0, 3) == 0) ? 64'd0 : rand_below((64'd1 << OFF_W) - len);
        set_region(base[OFF_W-1:0], len[OFF_W-1:0], bs[LEN_W-1:0]);
    endtask

    task automatic random_beat();
        logic [63:0] bs, nblk, start, blen, inb, off, ln, rel;
        logic st;
        int r;
        bs = (block_size_m == 0) ? 64'd1 : block_size_m;
        st = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        nblk = (region_len_m + bs - 1) / bs;
        if (nblk == 0) nblk = 1;
        // few distinct blocks so the two slots are reused often
        start = rand_below(nblk < 4 ? nblk : 4) * bs;
        blen = (start >= region_len_m) ? 64'd0 :
               ((bs < region_len_m - start) ? bs : region_len_m - start);
        off = region_base_m + start;
        ln = 0;
        if (r < 8) begin
            send_beat(CMD_RELEASE, st, 48'({$urandom, $urandom}), $urandom);
        end else if (r < 18) begin
            if (r < 13) begin
                off = {$urandom, $urandom};
            end else begin
                off = region_base_m + rand_below(region_len_m + 1);
            end
            ln = 64'($urandom);
            send_beat(CMD_RESOLVE, st, off[OFF_W-1:0], ln[LEN_W-1:0]);
        end else if (r < 24) begin
            if (r == 18 && region_base_m != 0) begin
                off = region_base_m - 1;
                ln = 64'($urandom_range(0, 2));
            end else begin
                rel = region_len_m - rand_below(region_len_m < 3 ? region_len_m + 1 : 3);
                off = region_base_m + rel;
                ln = region_len_m - rel + 64'($urandom_range(0, 1));
            end
            send_beat(CMD_RESOLVE, st, off[OFF_W-1:0], ln[LEN_W-1:0]);
        end else if (r < 32 && blen != 0) begin
            inb = blen - 1 - rand_below(blen < 8 ? blen : 8);
            off = off + inb;
            ln = blen - inb + 1 + rand_below(4);
            send_beat(CMD_RESOLVE, st, off[OFF_W-1:0], ln[LEN_W-1:0]);
        end else if (r < 36 || blen == 0) begin
            off = region_base_m + rand_below(region_len_m + 1);
            send_beat(CMD_RESOLVE, st, off[OFF_W-1:0], '0);
        end else begin
            inb = rand_below(blen);
            off = off + inb;
            ln = 1 + rand_below(($urandom_range(0, 1) != 0 && blen - inb > 16) ? 16 : blen - inb);
            send_beat(CMD_RESOLVE, st, off[OFF_W-1:0], ln[LEN_W-1:0]);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            repeat (4) begin
                random_region();
                repeat (90) random_beat();
            end
        end
    endtask

    initial begin
        #TIMEOUT;
        $display("pinned_block_region_cache_top test failed");
        $finish;
    end

    initial begin
        clear_mirror();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_window_edges();
        test_slot_pinning();
        test_block_size_extremes();
        test_random_traffic();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            mismatches++;
        end
        $display("Covered %0d request beats over %0d region settings: %0d releases, %0d range errors",
                 n_beats, n_settings, n_release, n_range);
        $display("  %0d empty, %0d slot hits, %0d slot fills, %0d scratch reads, %0d mismatches",
                 n_empty, n_hit, n_fill, n_scratch, mismatches);
        if (mismatches == 0) begin
            $display("pinned_block_region_cache_top test passed");
        end else begin
            $display("pinned_block_region_cache_top test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pbrc_pkg.sv
hw/rtl/pinned_block_region_cache_top.sv
dv/tb_pinned_block_region_cache_top.sv
